### hdl/tmb_pkg.sv
// shared types, codes and constants of the timer bank
package tmb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_REPORTS    = 16;
    localparam int CFG_DW         = 10;

    localparam logic [1:0] UNIT_TICKS   = 2'd0;
    localparam logic [1:0] UNIT_SECONDS = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_SET      = 3'd2,
        OP_GET      = 3'd3,
        OP_PAUSE    = 3'd4,
        OP_STOP     = 3'd5,
        OP_STOP_ALL = 3'd6,
        OP_SERVICE  = 3'd7
    } tmb_op_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REPORT = 2'd2
    } tmb_kind_t;

    typedef enum logic [1:0] {
        REG_TICKS_PER_TENTH    = 2'd0,
        REG_TENTHS_PER_SECOND  = 2'd1,
        REG_SECONDS_PER_MINUTE = 2'd2
    } tmb_reg_t;

    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_DEC      = 3'd1,
        WR_START    = 3'd2,
        WR_SET      = 3'd3,
        WR_PAUSE    = 3'd4,
        WR_STOP     = 3'd5,
        WR_STOP_ALL = 3'd6,
        WR_CLR_FLAG = 3'd7
    } tmb_wr_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FACT,
        ST_FWAIT,
        ST_OPWAIT,
        ST_EMIT,
        ST_TICK,
        ST_SERV
    } tmb_state_t;

    typedef struct packed {
        tmb_op_t     opcode;
        logic [3:0]  timer_index;
        logic [31:0] duration;
        logic [1:0]  unit;
        logic        pause;
    } tmb_in_t;

    typedef struct packed {
        tmb_kind_t   kind;
        logic [3:0]  result_index;
        logic [31:0] value;
        logic        last;
    } tmb_out_t;

    typedef struct packed {
        logic [9:0] ticks_per_tenth;
        logic [6:0] tenths_per_second;
        logic [6:0] seconds_per_minute;
    } tmb_cfg_t;

    typedef struct packed {
        tmb_wr_op_t  op;
        logic [31:0] count;
        logic [1:0]  unit;
        logic        pause;
    } tmb_wr_t;

    typedef struct packed {
        logic [31:0] count;
        logic [1:0]  unit;
        logic        expired;
    } tmb_rd_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] opa;
        logic [31:0] opb;
    } tmb_alu_req_t;

endpackage

### hdl/multi_timer_bank_with_units.sv
// top level of the countdown timer bank: configuration registers and unit wiring
//
// A bank of NUM_TIMERS countdown timers, each with a 32-bit tick count, an
// expired flag, a pause flag and a time unit (ticks, tenths, seconds,
// minutes). One operation is taken at a time; s_ready is high only while the
// block is idle, but a finished result may still sit in the output register
// while the next operation is taken. Tick and stop-all walk or clear the
// bank; service walks the bank one timer per cycle while the result side
// does not stall, and emits one report per expired timer, at most sixteen,
// or one acknowledge if none has expired. Start, set and get run through
// one shared 32-step shift-add multiplier / restoring divider; each extra
// scale factor, for seconds and minutes, is one more pass through that unit.
// The user must write the three scale registers through the cfg port only
// while the block is idle; the block does not enforce this. A zero register
// makes start expire at once and get read all ones.
module multi_timer_bank_with_units
    import tmb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // operation channel
    input  logic              s_valid,
    output logic              s_ready,
    input  tmb_in_t           s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output tmb_out_t          m_data,
    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // scale registers, reset to 100 ticks per tenth, 10 tenths, 60 seconds
    tmb_cfg_t cfg_reg, cfg_next;

    logic [AW-1:0]         file_addr;
    tmb_wr_t               file_wr;
    tmb_rd_t               file_rd;
    logic [NUM_TIMERS-1:0] expired_vec;
    tmb_alu_req_t          alu_req;
    logic                  alu_done;
    logic [31:0]           alu_result;

    // register decode; writes to an unused index are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TICKS_PER_TENTH:    cfg_next.ticks_per_tenth    = cfg_wdata[9:0];
                REG_TENTHS_PER_SECOND:  cfg_next.tenths_per_second  = cfg_wdata[6:0];
                REG_SECONDS_PER_MINUTE: cfg_next.seconds_per_minute = cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_tenth    <= 10'd100;
            cfg_reg.tenths_per_second  <= 7'd10;
            cfg_reg.seconds_per_minute <= 7'd60;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: decodes each operation, walks the bank, owns the result register
    tmb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg         (cfg_reg),
        .file_addr   (file_addr),
        .file_wr     (file_wr),
        .file_rd     (file_rd),
        .expired_vec (expired_vec),
        .alu_req     (alu_req),
        .alu_done    (alu_done),
        .alu_result  (alu_result)
    );

    // per-timer state, one addressed timer per cycle plus bank-wide clear
    tmb_timer_file #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_file (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .addr        (file_addr),
        .wr          (file_wr),
        .rd          (file_rd),
        .expired_vec (expired_vec)
    );

    // shared multiply / divide unit for scale factors, scaling and reads
    tmb_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .done    (alu_done),
        .result  (alu_result)
    );

endmodule

### hdl/tmb_muldiv.sv
// iterative 32-bit shift-add multiplier and restoring divider, one bit per cycle
module tmb_muldiv
    import tmb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  tmb_alu_req_t req,
    output logic         done,
    output logic [31:0]  result
);

    localparam int STEPS = 32;

    logic        run_reg;
    logic        done_reg;
    logic        div_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] acc_reg;
    logic [31:0] opa_reg;
    logic [31:0] opb_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] sum;

    always_comb begin
        trial = {acc_reg[31:0], opa_reg[31]};
        ge    = (trial >= {1'b0, opb_reg});
        diff  = trial - {1'b0, opb_reg};
        sum   = acc_reg[31:0] + (opb_reg[0] ? opa_reg : 32'd0);
    end

    // a zero divisor gives an all-ones quotient by itself
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (cnt_reg == 5'(STEPS - 1));
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                div_reg <= req.is_div;
                acc_reg <= '0;
                opa_reg <= req.opa;
                opb_reg <= req.opb;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEPS - 1)) begin
                    run_reg <= 1'b0;
                end
                if (div_reg) begin
                    acc_reg <= ge ? diff : trial;
                    opa_reg <= {opa_reg[30:0], ge};
                end else begin
                    acc_reg <= {1'b0, sum};
                    opa_reg <= {opa_reg[30:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[31:1]};
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = div_reg ? opa_reg : acc_reg[31:0];

endmodule

### hdl/tmb_timer_file.sv
// per-timer state: counts, units, expired and paused flags
module tmb_timer_file
    import tmb_pkg::*;
#(
    parameter  int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [AW-1:0]         addr,
    input  tmb_wr_t               wr,
    output tmb_rd_t               rd,
    output logic [NUM_TIMERS-1:0] expired_vec
);

    logic [31:0]           count_reg [NUM_TIMERS];
    logic [1:0]            unit_reg  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] expired_reg;
    logic [NUM_TIMERS-1:0] paused_reg;

    logic        hit;
    logic        paused_here;
    logic [31:0] dec_val;

    always_comb begin
        hit         = (int'(addr) < NUM_TIMERS);
        rd          = '0;
        paused_here = 1'b0;
        if (hit) begin
            rd.count    = count_reg[addr];
            rd.unit     = unit_reg[addr];
            rd.expired  = expired_reg[addr];
            paused_here = paused_reg[addr];
        end
        dec_val = rd.count - 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i] <= '0;
                unit_reg[i]  <= UNIT_TICKS;
            end
            expired_reg <= '0;
            paused_reg  <= '0;
        end else begin
            unique case (wr.op)
                WR_DEC: begin
                    if (hit && (rd.count != 32'd0) && !paused_here) begin
                        count_reg[addr] <= dec_val;
                        if (dec_val == 32'd0) begin
                            expired_reg[addr] <= 1'b1;
                        end
                    end
                end
                WR_START: begin
                    if (hit) begin
                        count_reg[addr]   <= wr.count;
                        unit_reg[addr]    <= wr.unit;
                        expired_reg[addr] <= (wr.count == 32'd0);
                    end
                end
                WR_SET: begin
                    if (hit) begin
                        count_reg[addr] <= wr.count;
                    end
                end
                WR_PAUSE: begin
                    if (hit) begin
                        paused_reg[addr] <= wr.pause;
                    end
                end
                WR_STOP: begin
                    if (hit) begin
                        count_reg[addr]   <= '0;
                        unit_reg[addr]    <= UNIT_TICKS;
                        expired_reg[addr] <= 1'b0;
                        paused_reg[addr]  <= 1'b0;
                    end
                end
                WR_STOP_ALL: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        count_reg[i] <= '0;
                        unit_reg[i]  <= UNIT_TICKS;
                    end
                    expired_reg <= '0;
                    paused_reg  <= '0;
                end
                WR_CLR_FLAG: begin
                    if (hit) begin
                        expired_reg[addr] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign expired_vec = expired_reg;

endmodule

### hdl/tmb_ctrl.sv
// operation sequencer, timer walk, operand routing and result register
module tmb_ctrl
    import tmb_pkg::*;
#(
    parameter  int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tmb_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tmb_out_t              m_data,
    input  tmb_cfg_t              cfg,
    output logic [AW-1:0]         file_addr,
    output tmb_wr_t               file_wr,
    input  tmb_rd_t               file_rd,
    input  logic [NUM_TIMERS-1:0] expired_vec,
    output tmb_alu_req_t          alu_req,
    input  logic                  alu_done,
    input  logic [31:0]           alu_result
);

    localparam int NRW = $clog2(MAX_REPORTS + 1);

    tmb_state_t  state_reg, state_next;

    tmb_op_t     op_reg, op_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] dur_reg, dur_next;
    logic [1:0]  un_in_reg, un_in_next;
    logic        pz_reg, pz_next;
    logic        ok_reg, ok_next;

    logic [1:0]  u_reg, u_next;
    logic [31:0] f_reg, f_next;
    logic [2:0]  fstep_reg, fstep_next;
    logic [31:0] count_reg, count_next;

    tmb_kind_t   r_kind_reg, r_kind_next;
    logic [3:0]  r_idx_reg, r_idx_next;
    logic [31:0] r_val_reg, r_val_next;

    logic [AW-1:0]  scan_reg, scan_next;
    logic [NRW-1:0] nrep_reg, nrep_next;

    logic     m_valid_reg, m_valid_next;
    tmb_out_t m_data_reg, m_data_next;

    logic     accept;
    logic     out_free;
    logic     out_load;
    tmb_out_t out_data;
    logic     scan_last;
    logic     apply;
    logic     more;
    logic     rep_last;

    always_comb begin
        accept    = s_valid && s_ready;
        out_free  = !m_valid_reg || m_ready;
        scan_last = (scan_reg == AW'(NUM_TIMERS - 1));
        apply     = ({1'b0, u_reg} >= fstep_reg);
        more      = 1'b0;
        for (int j = 0; j < NUM_TIMERS; j++) begin
            if ((j > int'(scan_reg)) && expired_vec[j]) begin
                more = 1'b1;
            end
        end
        rep_last = !more || (nrep_reg == NRW'(MAX_REPORTS - 1));
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.opcode) inside
                        OP_TICK:    state_next = ST_TICK;
                        OP_SERVICE: state_next = ST_SERV;
                        default:    state_next = ST_LOAD;
                    endcase
                end
            end
            ST_LOAD: begin
                unique case (op_reg) inside
                    OP_START, OP_SET, OP_GET: state_next = ok_reg ? ST_FACT : ST_EMIT;
                    default:                  state_next = ST_EMIT;
                endcase
            end
            ST_FACT:   state_next = apply ? ST_FWAIT : ST_OPWAIT;
            ST_FWAIT:  state_next = alu_done ? ST_FACT : ST_FWAIT;
            ST_OPWAIT: state_next = alu_done ? ST_EMIT : ST_OPWAIT;
            ST_EMIT:   state_next = out_free ? ST_IDLE : ST_EMIT;
            ST_TICK:   state_next = scan_last ? ST_EMIT : ST_TICK;
            ST_SERV: begin
                if (file_rd.expired) begin
                    if (out_free && (rep_last || scan_last)) begin
                        state_next = ST_IDLE;
                    end
                end else if (scan_last) begin
                    state_next = (nrep_reg == '0) ? ST_EMIT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs toward the timer file, the shared unit and the result register
    always_comb begin
        file_addr = AW'(idx_reg);
        file_wr   = '0;
        alu_req   = '0;
        out_load  = 1'b0;
        out_data  = '{kind: r_kind_reg, result_index: r_idx_reg, value: r_val_reg,
                      last: 1'b1};
        unique case (state_reg)
            ST_LOAD: begin
                if (ok_reg) begin
                    unique case (op_reg) inside
                        OP_PAUSE: begin
                            file_wr.op    = WR_PAUSE;
                            file_wr.pause = pz_reg;
                        end
                        OP_STOP: file_wr.op = WR_STOP;
                        default: begin
                        end
                    endcase
                end
                if (op_reg == OP_STOP_ALL) begin
                    file_wr.op = WR_STOP_ALL;
                end
            end
            ST_FACT: begin
                alu_req.start = 1'b1;
                if (apply) begin
                    alu_req.opa = f_reg;
                    alu_req.opb = (fstep_reg == {1'b0, UNIT_SECONDS}) ?
                                  32'(cfg.tenths_per_second) : 32'(cfg.seconds_per_minute);
                end else if (op_reg == OP_GET) begin
                    alu_req.is_div = 1'b1;
                    alu_req.opa    = count_reg;
                    alu_req.opb    = f_reg;
                end else begin
                    alu_req.opa = dur_reg;
                    alu_req.opb = f_reg;
                end
            end
            ST_OPWAIT: begin
                if (alu_done) begin
                    file_wr.count = alu_result;
                    file_wr.unit  = u_reg;
                    if (op_reg == OP_START) begin
                        file_wr.op = WR_START;
                    end else if (op_reg == OP_SET) begin
                        file_wr.op = WR_SET;
                    end
                end
            end
            ST_EMIT: out_load = out_free;
            ST_TICK: begin
                file_addr  = scan_reg;
                file_wr.op = WR_DEC;
            end
            ST_SERV: begin
                file_addr = scan_reg;
                if (file_rd.expired && out_free) begin
                    file_wr.op = WR_CLR_FLAG;
                    out_load   = 1'b1;
                    out_data   = '{kind: KIND_REPORT, result_index: 4'(scan_reg),
                                   value: 32'd0, last: rep_last};
                end
            end
            default: begin
            end
        endcase
    end

    // working registers
    always_comb begin
        op_next     = op_reg;
        idx_next    = idx_reg;
        dur_next    = dur_reg;
        un_in_next  = un_in_reg;
        pz_next     = pz_reg;
        ok_next     = ok_reg;
        u_next      = u_reg;
        f_next      = f_reg;
        fstep_next  = fstep_reg;
        count_next  = count_reg;
        r_kind_next = r_kind_reg;
        r_idx_next  = r_idx_reg;
        r_val_next  = r_val_reg;
        scan_next   = scan_reg;
        nrep_next   = nrep_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next     = s_data.opcode;
                    idx_next    = s_data.timer_index;
                    dur_next    = s_data.duration;
                    un_in_next  = s_data.unit;
                    pz_next     = s_data.pause;
                    ok_next     = (int'(s_data.timer_index) < NUM_TIMERS);
                    r_kind_next = (s_data.opcode == OP_GET) ? KIND_READ : KIND_ACK;
                    r_idx_next  = s_data.timer_index;
                    if ((s_data.opcode == OP_TICK) || (s_data.opcode == OP_STOP_ALL) ||
                        (s_data.opcode == OP_SERVICE)) begin
                        r_idx_next = 4'd0;
                    end
                    r_val_next = 32'd0;
                    scan_next  = '0;
                    nrep_next  = '0;
                end
            end
            ST_LOAD: begin
                u_next     = (op_reg == OP_START) ? un_in_reg : file_rd.unit;
                count_next = file_rd.count;
                f_next     = (u_next == UNIT_TICKS) ? 32'd1 : 32'(cfg.ticks_per_tenth);
                fstep_next = {1'b0, UNIT_SECONDS};
            end
            ST_FWAIT: begin
                if (alu_done) begin
                    f_next     = alu_result;
                    fstep_next = fstep_reg + 3'd1;
                end
            end
            ST_OPWAIT: begin
                if (alu_done && (op_reg == OP_GET)) begin
                    r_val_next = alu_result;
                end
            end
            ST_TICK: scan_next = scan_reg + AW'(1);
            ST_SERV: begin
                if (file_rd.expired) begin
                    if (out_free) begin
                        nrep_next = nrep_reg + NRW'(1);
                        scan_next = scan_reg + AW'(1);
                    end
                end else begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = out_load || (m_valid_reg && !m_ready);
        m_data_next  = out_load ? out_data : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            nrep_reg    <= '0;
            scan_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            nrep_reg    <= nrep_next;
            scan_reg    <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        dur_reg    <= dur_next;
        un_in_reg  <= un_in_next;
        pz_reg     <= pz_next;
        ok_reg     <= ok_next;
        u_reg      <= u_next;
        f_reg      <= f_next;
        fstep_reg  <= fstep_next;
        count_reg  <= count_next;
        r_kind_reg <= r_kind_next;
        r_idx_reg  <= r_idx_next;
        r_val_reg  <= r_val_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("block still idle after an input transfer");

    a_no_stray_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !alu_done)
        else $error("shared unit finished with no operation waiting");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten before its transfer");

    a_report_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        nrep_reg <= NRW'(MAX_REPORTS))
        else $error("more expired reports than allowed in one service");

endmodule
